// File: rtl/pipc_pkg.sv
// Shared constants and helpers for the point-in-polygon crossing test.
package pipc_pkg;

	// Width of the result field carried on the output stream
	localparam int INSIDE_W = 1;

	// Round a field width up to whole bytes for stream data buses
	function automatic int pad_bytes(input int bits);
		return ((bits + 7) / 8) * 8;
	endfunction

endpackage

// File: rtl/pipc_mul.sv
// Shared registered signed-by-unsigned multiplier for the edge crossing terms.
module pipc_mul
	import pipc_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic signed [COORD_BITS:0]       a,   // signed coordinate offset
	input  logic        [COORD_BITS+1:0]     b,   // non-negative weight
	output logic signed [2*COORD_BITS+3:0]   p_s1
);

	logic signed [COORD_BITS+2:0] b_sgn;

	assign b_sgn = $signed({1'b0, b});

	// One product per enabled cycle, held otherwise
	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= (2*COORD_BITS+4)'(a) * (2*COORD_BITS+4)'(b_sgn);
		end
	end

endmodule

// File: rtl/point_in_polygon_crossing_test_top.sv
// Top level of the point-in-polygon ray crossing test.
//
// Usage: one request on the s_ stream carries the query point and one polygon
// vertex. s_tuser marks the first vertex of a polygon, s_tlast the last one.
// Each vertex after the first closes an edge with the previous vertex; the
// edge is intersected with the diagonal ray z = x + (pz - px) toward +x and
// a parity bit toggles on a hit. On the last vertex one request leaves on the
// m_ stream with m_tdata[0] = 1 when the point is inside.
// Steps: a vertex with a tested edge passes edge setup, two products through
// the one shared multiplier, and final sum and compare, then returns to idle;
// a skipped edge (parallel to the ray, repeated vertex, or hit outside the
// edge span) goes from edge setup to the final step, and a vertex that opens
// a polygon goes from idle to the final step. New vertices wait until idle.
// Output: m_tvalid is set by the output register when the final step of a last
// vertex loads it.
// Stalls: the output register holds a result while m_tready is low; new
// vertices are still accepted, and only a further last vertex waits in its
// final step until the held result is taken.
// Reset: arst_n clears the previous vertex to zero, the parity, the
// have-previous flag and the output valid; no clearing pass is needed.
module point_in_polygon_crossing_test_top
	import pipc_pkg::*;
#(
	parameter  int COORD_BITS = 16,
	localparam int S_TDATA_W  = pad_bytes(4 * COORD_BITS),
	localparam int M_TDATA_W  = pad_bytes(INSIDE_W)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// point_x, point_z, vertex_x, vertex_z (COORD_BITS each), zero pad
	input  logic [S_TDATA_W-1:0] s_tdata,
	// first_vertex
	input  logic [0:0]           s_tuser,
	input  logic                 s_tlast,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// inside_res, zero pad
	output logic [M_TDATA_W-1:0] m_tdata
);

	localparam int W = COORD_BITS;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EDGE,
		ST_MULA,
		ST_MULB,
		ST_FIN
	} state_t;

	state_t state_q;

	logic signed [W-1:0] px_q, pz_q, bx_q, bz_q;
	logic signed [W-1:0] prev_x_q, prev_z_q;
	logic                have_prev_q, parity_q, clr_q, last_q, calc_q;
	logic signed [W:0]   ua_q, ub_q;
	logic        [W+1:0] dmn_q, num_q;
	logic signed [2*W+4:0] acc_q;
	logic                m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	logic signed [W+1:0] den_w, num_w, den_abs, num_adj;
	logic                edge_ok;
	logic                mul_en;
	logic signed [W:0]   mul_a;
	logic        [W+1:0] mul_b;
	logic signed [2*W+3:0] prod;
	logic signed [2*W+4:0] sum;
	logic                hit, par_new, out_busy, out_load, s_acc;

	// Edge setup: ray-relative denominator and numerator, sign normalized
	always_comb begin
		den_w = (W+2)'(bz_q) - (W+2)'(prev_z_q) - (W+2)'(bx_q) + (W+2)'(prev_x_q);
		num_w = (W+2)'(pz_q) - (W+2)'(px_q) - (W+2)'(prev_z_q) + (W+2)'(prev_x_q);
		den_abs = den_w[W+1] ? -den_w : den_w;
		num_adj = den_w[W+1] ? -num_w : num_w;
		edge_ok = (den_w != '0) && !num_adj[W+1] && (num_adj <= den_abs);
	end

	// Multiplier operand select per step
	always_comb begin
		mul_en = (state_q == ST_MULA) || (state_q == ST_MULB);
		mul_a  = (state_q == ST_MULB) ? ub_q : ua_q;
		mul_b  = (state_q == ST_MULB) ? num_q : dmn_q;
	end

	pipc_mul #(
		.COORD_BITS(W)
	) u_mul (
		.clk  (clk),
		.en   (mul_en),
		.a    (mul_a),
		.b    (mul_b),
		.p_s1 (prod)
	);

	// Final sum of both weighted terms and new parity
	always_comb begin
		sum     = acc_q + (2*W+5)'(prod);
		hit     = calc_q && !sum[2*W+4] && (sum != '0);
		par_new = clr_q ? 1'b0 : (parity_q ^ hit);
	end

	assign out_busy = m_tvalid_q && !m_tready;
	assign out_load = (state_q == ST_FIN) && last_q && !out_busy;
	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Sequencer, state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_x_q    <= '0;
			prev_z_q    <= '0;
			have_prev_q <= 1'b0;
			parity_q    <= 1'b0;
			clr_q       <= 1'b0;
			last_q      <= 1'b0;
			calc_q      <= 1'b0;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
		end else begin
			// Load a new result, else drop the one just taken
			if (out_load) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= M_TDATA_W'(par_new);
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						clr_q   <= s_tuser[0] || !have_prev_q;
						last_q  <= s_tlast;
						calc_q  <= 1'b0;
						state_q <= (s_tuser[0] || !have_prev_q) ? ST_FIN : ST_EDGE;
					end
				end
				ST_EDGE: begin
					calc_q  <= edge_ok;
					state_q <= edge_ok ? ST_MULA : ST_FIN;
				end
				ST_MULA: begin
					state_q <= ST_MULB;
				end
				ST_MULB: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!(last_q && out_busy)) begin
						prev_x_q <= bx_q;
						prev_z_q <= bz_q;
						state_q  <= ST_IDLE;
						if (last_q) begin
							parity_q    <= 1'b0;
							have_prev_q <= 1'b0;
						end else begin
							parity_q    <= par_new;
							have_prev_q <= 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (s_acc) begin
			px_q <= s_tdata[W-1:0];
			pz_q <= s_tdata[2*W-1:W];
			bx_q <= s_tdata[3*W-1:2*W];
			bz_q <= s_tdata[4*W-1:3*W];
		end
		if (state_q == ST_EDGE) begin
			ua_q  <= (W+1)'(prev_x_q) - (W+1)'(px_q);
			ub_q  <= (W+1)'(bx_q) - (W+1)'(px_q);
			dmn_q <= den_abs - num_adj;
			num_q <= num_adj;
		end
		if (state_q == ST_MULB) begin
			acc_q <= (2*W+5)'(prod);
		end
	end

endmodule

// File: rtl/pipc_checker.sv
// Port-level checker for the crossing test top level, with its bind.
module pipc_checker
	import pipc_pkg::*;
#(
	parameter  int COORD_BITS = 16,
	localparam int S_TDATA_W  = pad_bytes(4 * COORD_BITS),
	localparam int M_TDATA_W  = pad_bytes(INSIDE_W)
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic [S_TDATA_W-1:0] s_tdata,
	input logic [0:0]           s_tuser,
	input logic                 s_tlast,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	// No result shows while reset is held
	a_rst_quiet: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("m_tvalid high during reset");

	// A waiting request holds its payload
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && !s_tready) |=>
		(s_tvalid && $stable(s_tdata) && $stable(s_tuser) && $stable(s_tlast)))
		else $error("waiting request changed");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");

	// s_tready is low in the cycle after a request is accepted
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("ready right after a request");

	// Only a last vertex can raise a new result
	a_last_only: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && !s_tlast) |-> ##2 !$rose(m_tvalid))
		else $error("result raised without a last vertex");

endmodule

bind point_in_polygon_crossing_test_top pipc_checker #(
	.COORD_BITS(COORD_BITS)
) u_pipc_checker (.*);
